/* rtl/scaled_euclidean_norm_defines.svh */
// Assertion macros shared by the scaled Euclidean norm RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SCALED_EUCLIDEAN_NORM_DEFINES_SVH
`define SCALED_EUCLIDEAN_NORM_DEFINES_SVH

// same-cycle implication
`define SEN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sen_pkg.sv */
// Types and constants of the scaled Euclidean norm block.
// No dependencies; used by sen_fpu and scaled_euclidean_norm.
`default_nettype none

package sen_pkg;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } fpu_op_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  localparam logic [63:0] DBL_ZERO     = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NORM_MAX = 64'h4A51_1B0E_C57E_649A;  // 1.0e50
  localparam logic [63:0] DBL_INF      = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_QBIT     = 64'h0008_0000_0000_0000;

endpackage

`default_nettype wire

/* rtl/sen_fpu.sv */
// Shared iterative double unit: add, multiply, divide, square root.
// Operands are non-negative or NaN. Depends on sen_pkg.
`default_nettype none

module sen_fpu import sen_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fpu_req_t req_i,
  output fpu_rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_SPEC, F_NRM, F_MUL, F_DIV, F_ADD, F_SQRT, F_SQF, F_NORM, F_DEN, F_RND
  } fstate_e;

  fstate_e            st_q;
  fpu_op_e            op_q;
  logic [63:0]        a_q, b_q;
  logic [52:0]        ma_q, mb_q;
  logic signed [13:0] ea_q, eb_q;
  logic [5:0]         cnt_q;
  logic [105:0]       acc_q;
  logic [54:0]        rem_q;
  logic [62:0]        quo_q;
  logic [56:0]        rr_q;
  logic [53:0]        qq_q;
  logic [53:0]        mm_q;
  logic [63:0]        m_q;
  logic signed [13:0] e_q;
  logic               stk_q;
  logic [63:0]        res_q;
  logic               done_q;

  // operand classes
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [52:0] ua_m, ub_m;
  logic signed [13:0] ua_e, ub_e;
  logic spec_hit;
  logic [63:0] spec_res;

  always_comb begin
    a_nan  = (&a_q[62:52]) && (|a_q[51:0]);
    a_inf  = (&a_q[62:52]) && !(|a_q[51:0]);
    a_zero = (a_q[62:0] == 63'd0);
    b_nan  = (&b_q[62:52]) && (|b_q[51:0]);
    b_inf  = (&b_q[62:52]) && !(|b_q[51:0]);
    b_zero = (b_q[62:0] == 63'd0);
    ua_m = (a_q[62:52] == 11'd0) ? {1'b0, a_q[51:0]} : {1'b1, a_q[51:0]};
    ub_m = (b_q[62:52] == 11'd0) ? {1'b0, b_q[51:0]} : {1'b1, b_q[51:0]};
    ua_e = (a_q[62:52] == 11'd0) ? -14'sd1022 : $signed({3'b000, a_q[62:52]}) - 14'sd1023;
    ub_e = (b_q[62:52] == 11'd0) ? -14'sd1022 : $signed({3'b000, b_q[62:52]}) - 14'sd1023;

    spec_hit = 1'b1;
    spec_res = DBL_QNAN;
    case (op_q)
      OP_SQRT: begin
        if (a_nan) spec_res = a_q | DBL_QBIT;
        else if (a_inf || a_zero) spec_res = a_q;
        else spec_hit = 1'b0;
      end
      OP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) spec_res = DBL_QNAN;
        else if (a_inf || b_inf) spec_res = DBL_INF;
        else if (a_zero || b_zero) spec_res = DBL_ZERO;
        else spec_hit = 1'b0;
      end
      OP_DIV: begin
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) spec_res = DBL_QNAN;
        else if (a_inf || b_zero) spec_res = DBL_INF;
        else if (a_zero || b_inf) spec_res = DBL_ZERO;
        else spec_hit = 1'b0;
      end
      OP_ADD: begin
        if (a_nan || b_nan) spec_res = DBL_QNAN;
        else if (a_inf || b_inf) spec_res = DBL_INF;
        else if (a_zero) spec_res = {1'b0, b_q[62:0]};
        else if (b_zero) spec_res = {1'b0, a_q[62:0]};
        else spec_hit = 1'b0;
      end
      default: spec_res = DBL_QNAN;
    endcase
  end

  // one step of each iterative loop
  logic [105:0] acc_n;
  logic         div_ge;
  logic [54:0]  rem_sub, rem_n;
  logic [56:0]  sq_rn, sq_tn, rr_n;
  logic         sq_ge;
  logic [53:0]  qq_n;

  always_comb begin
    acc_n   = {acc_q[104:0], 1'b0} + (ma_q[52] ? {53'd0, mb_q} : 106'd0);
    div_ge  = rem_q >= {2'b00, mb_q};
    rem_sub = div_ge ? rem_q - {2'b00, mb_q} : rem_q;
    rem_n   = {rem_sub[53:0], 1'b0};
    sq_rn   = {rr_q[54:0], mm_q[53:52]};
    sq_tn   = {1'b0, qq_q, 2'b01};
    sq_ge   = sq_rn >= sq_tn;
    rr_n    = sq_ge ? sq_rn - sq_tn : sq_rn;
    qq_n    = {qq_q[52:0], sq_ge};
  end

  // alignment for add
  logic               a_big;
  logic [63:0]        add_big, add_sml, add_sh;
  logic signed [13:0] add_e;
  logic [13:0]        add_d;
  logic               add_lost;

  always_comb begin
    a_big   = ea_q >= eb_q;
    add_big = a_big ? {1'b0, ma_q, 10'd0} : {1'b0, mb_q, 10'd0};
    add_sml = a_big ? {1'b0, mb_q, 10'd0} : {1'b0, ma_q, 10'd0};
    add_e   = a_big ? ea_q : eb_q;
    add_d   = a_big ? 14'(ea_q - eb_q) : 14'(eb_q - ea_q);
    if (add_d[13:6] != 8'd0) begin
      add_sh   = 64'd0;
      add_lost = |add_sml;
    end else begin
      add_sh   = add_sml >> add_d[5:0];
      add_lost = |(add_sml & ((64'd1 << add_d[5:0]) - 64'd1));
    end
  end

  // subnormal shift, rounding, packing
  logic [13:0]  den_sh;
  logic [63:0]  den_m;
  logic         den_lost;
  logic [52:0]  rnd_keep;
  logic         rnd_up;
  logic [53:0]  rnd_k;
  logic [13:0]  rnd_ex;
  logic [63:0]  rnd_res;
  logic [53:0]  sq_qf;
  logic [13:0]  sq_ex;

  always_comb begin
    den_sh = 14'(-14'sd1022 - e_q);
    if (den_sh[13:6] != 8'd0) begin
      den_m    = 64'd0;
      den_lost = |m_q;
    end else begin
      den_m    = m_q >> den_sh[5:0];
      den_lost = |(m_q & ((64'd1 << den_sh[5:0]) - 64'd1));
    end
    rnd_keep = m_q[62:10];
    rnd_up   = m_q[9] && ((|m_q[8:0]) || stk_q || rnd_keep[0]);
    rnd_k    = {1'b0, rnd_keep} + {53'd0, rnd_up};
    rnd_ex   = 14'(e_q + 14'sd1022) + {12'd0, rnd_k[53:52]};
    rnd_res  = (rnd_ex >= 14'd2047) ? DBL_INF : {1'b0, rnd_ex[10:0], rnd_k[51:0]};
    sq_qf    = (rr_q > {3'b000, qq_q}) ? qq_q + 54'd1 : qq_q;
    sq_ex    = 14'((ea_q >>> 1) + 14'sd1048) + {12'd0, sq_qf[53:52]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      op_q   <= OP_ADD;
      a_q    <= '0;
      b_q    <= '0;
      ma_q   <= '0;
      mb_q   <= '0;
      ea_q   <= '0;
      eb_q   <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      rr_q   <= '0;
      qq_q   <= '0;
      mm_q   <= '0;
      m_q    <= '0;
      e_q    <= '0;
      stk_q  <= 1'b0;
      res_q  <= '0;
      done_q <= 1'b0;
    end else begin
      case (st_q)
        F_IDLE: begin
          // every result pulse lands here, so the idle state ends it
          done_q <= 1'b0;
          if (req_i.start) begin
            op_q <= req_i.op;
            a_q  <= req_i.a;
            b_q  <= req_i.b;
            st_q <= F_SPEC;
          end
        end
        F_SPEC: begin
          if (spec_hit) begin
            res_q  <= spec_res;
            done_q <= 1'b1;
            st_q   <= F_IDLE;
          end else begin
            ma_q <= ua_m;
            ea_q <= ua_e;
            mb_q <= (op_q == OP_SQRT) ? {1'b1, 52'd0} : ub_m;
            eb_q <= (op_q == OP_SQRT) ? 14'sd0 : ub_e;
            st_q <= F_NRM;
          end
        end
        F_NRM: begin
          if (!ma_q[52] || !mb_q[52]) begin
            // subnormal operands: one bit a cycle
            if (!ma_q[52]) begin
              ma_q <= {ma_q[51:0], 1'b0};
              ea_q <= ea_q - 14'sd1;
            end
            if (!mb_q[52]) begin
              mb_q <= {mb_q[51:0], 1'b0};
              eb_q <= eb_q - 14'sd1;
            end
          end else begin
            case (op_q)
              OP_MUL: begin
                acc_q <= '0;
                cnt_q <= 6'd52;
                st_q  <= F_MUL;
              end
              OP_DIV: begin
                rem_q <= {2'b00, ma_q};
                quo_q <= '0;
                cnt_q <= 6'd62;
                st_q  <= F_DIV;
              end
              OP_SQRT: begin
                if (ea_q[0]) begin
                  mm_q <= {ma_q, 1'b0};
                  ea_q <= ea_q - 14'sd53;
                end else begin
                  mm_q <= {1'b0, ma_q};
                  ea_q <= ea_q - 14'sd52;
                end
                rr_q  <= '0;
                qq_q  <= '0;
                cnt_q <= 6'd52;
                st_q  <= F_SQRT;
              end
              default: st_q <= F_ADD;
            endcase
          end
        end
        F_MUL: begin
          acc_q <= acc_n;
          ma_q  <= {ma_q[51:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            m_q   <= acc_n[105:42];
            stk_q <= |acc_n[41:0];
            e_q   <= ea_q + eb_q;
            st_q  <= F_NORM;
          end
        end
        F_DIV: begin
          quo_q <= {quo_q[61:0], div_ge};
          rem_q <= rem_n;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            m_q   <= {1'b0, quo_q[61:0], div_ge};
            stk_q <= |rem_n;
            e_q   <= ea_q - eb_q;
            st_q  <= F_NORM;
          end
        end
        F_ADD: begin
          m_q   <= add_big + add_sh;
          stk_q <= add_lost;
          e_q   <= add_e;
          st_q  <= F_NORM;
        end
        F_SQRT: begin
          rr_q  <= rr_n;
          qq_q  <= qq_n;
          mm_q  <= {mm_q[51:0], 2'b00};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) st_q <= F_SQF;
        end
        F_SQF: begin
          res_q  <= {1'b0, sq_ex[10:0], sq_qf[51:0]};
          done_q <= 1'b1;
          st_q   <= F_IDLE;
        end
        F_NORM: begin
          if (m_q == 64'd0) begin
            res_q  <= DBL_ZERO;
            done_q <= 1'b1;
            st_q   <= F_IDLE;
          end else if (m_q[63]) begin
            m_q   <= {1'b0, m_q[63:1]};
            stk_q <= stk_q | m_q[0];
            e_q   <= e_q + 14'sd1;
          end else if (!m_q[62]) begin
            m_q <= {m_q[62:0], 1'b0};
            e_q <= e_q - 14'sd1;
          end else begin
            st_q <= F_DEN;
          end
        end
        F_DEN: begin
          if (e_q < -14'sd1022) begin
            m_q   <= den_m;
            stk_q <= stk_q | den_lost;
            e_q   <= -14'sd1022;
          end
          st_q <= F_RND;
        end
        F_RND: begin
          res_q  <= rnd_res;
          done_q <= 1'b1;
          st_q   <= F_IDLE;
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (st_q != F_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

/* rtl/scaled_euclidean_norm.sv */
// Scaled Euclidean norm of a stream of doubles; sequencer over sen_fpu (uses sen_pkg).
// Work per element: a nonzero element runs up to one 63-step divide, up to two 53-step
// multiplies and an add on the shared unit; a zero element skips the unit, and zero,
// infinite or NaN operands finish an operation without iterating. The last element
// adds a 53-step root, a divide and a multiply; subnormals add a shift per bit each.
// One item is in work at a time; a waiting result does not block input. Reset clears all.
`default_nettype none
`include "scaled_euclidean_norm_defines.svh"

module scaled_euclidean_norm import sen_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] element_bits
  input  wire logic        s_axis_tlast_i,   // last_element
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o    // [63:0] norm_bits
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK,
    S_BDIV, S_BMUL1, S_BMUL2, S_BADD,   // new largest magnitude: rescale sum
    S_SDIV, S_SMUL, S_SADD,             // smaller magnitude: add squared ratio
    S_AFTER, S_SQRT, S_QDIV, S_CLAMP, S_FMUL, S_EMIT
  } state_e;

  state_e      st_q;
  logic        issued_q;
  logic [63:0] mag_q;      // element with sign cleared
  logic        last_q;
  logic [63:0] scale_q;    // running scale
  logic [63:0] ss_q;       // scaled sum of squares
  logic        seen_q;     // current vector has had a non-last element
  logic [63:0] tmp_q;      // ratio, or 1e50 / root
  logic [63:0] tmp2_q;     // products
  logic [63:0] root_q;
  logic [63:0] res_q;
  logic        m_valid_q;
  logic [63:0] m_data_q;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  // x < y for non-negative x that is never NaN; false when y is NaN
  function automatic logic lt_pos(input logic [63:0] x, input logic [63:0] y);
    logic y_nan;
    y_nan  = (&y[62:52]) && (|y[51:0]);
    lt_pos = !y_nan && (x[62:0] < y[62:0]);
  endfunction

  // shared unit request for each step
  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = OP_ADD;
    fpu_req.a     = DBL_ZERO;
    fpu_req.b     = DBL_ZERO;
    case (st_q)
      S_BDIV:  begin fpu_req.op = OP_DIV;  fpu_req.a = scale_q;      fpu_req.b = mag_q;  end
      S_BMUL1: begin fpu_req.op = OP_MUL;  fpu_req.a = ss_q;         fpu_req.b = tmp_q;  end
      S_BMUL2: begin fpu_req.op = OP_MUL;  fpu_req.a = tmp2_q;       fpu_req.b = tmp_q;  end
      S_BADD:  begin fpu_req.op = OP_ADD;  fpu_req.a = DBL_ONE;      fpu_req.b = tmp2_q; end
      S_SDIV:  begin fpu_req.op = OP_DIV;  fpu_req.a = mag_q;        fpu_req.b = scale_q; end
      S_SMUL:  begin fpu_req.op = OP_MUL;  fpu_req.a = tmp_q;        fpu_req.b = tmp_q;  end
      S_SADD:  begin fpu_req.op = OP_ADD;  fpu_req.a = ss_q;         fpu_req.b = tmp2_q; end
      S_SQRT:  begin fpu_req.op = OP_SQRT; fpu_req.a = ss_q;         fpu_req.b = DBL_ZERO; end
      S_QDIV:  begin fpu_req.op = OP_DIV;  fpu_req.a = DBL_NORM_MAX; fpu_req.b = root_q; end
      S_FMUL:  begin fpu_req.op = OP_MUL;  fpu_req.a = scale_q;      fpu_req.b = root_q; end
      default: fpu_req.op = OP_ADD;
    endcase
    case (st_q)
      S_BDIV, S_BMUL1, S_BMUL2, S_BADD, S_SDIV, S_SMUL, S_SADD,
      S_SQRT, S_QDIV, S_FMUL: fpu_req.start = !issued_q;
      default: fpu_req.start = 1'b0;
    endcase
  end

  sen_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      issued_q  <= 1'b0;
      mag_q     <= '0;
      last_q    <= 1'b0;
      scale_q   <= DBL_ZERO;
      ss_q      <= DBL_ONE;
      seen_q    <= 1'b0;
      tmp_q     <= '0;
      tmp2_q    <= '0;
      root_q    <= '0;
      res_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // S_EMIT handles the output register itself
      if (m_valid_q && m_axis_tready_i && (st_q != S_EMIT)) m_valid_q <= 1'b0;
      if (fpu_req.start) issued_q <= 1'b1;

      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            mag_q  <= {1'b0, s_axis_tdata_i[62:0]};
            last_q <= s_axis_tlast_i;
            st_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (last_q && !seen_q) begin
            // single-element vector: its magnitude, no clamp
            res_q <= mag_q;
            st_q  <= S_EMIT;
          end else if (mag_q[62:0] == 63'd0) begin
            st_q <= S_AFTER;
          end else if (lt_pos(scale_q, mag_q)) begin
            st_q <= S_BDIV;
          end else if (scale_q[62:0] == 63'd0) begin
            tmp_q <= mag_q;   // ratio is the element itself
            st_q  <= S_SMUL;
          end else begin
            st_q <= S_SDIV;
          end
        end
        S_BDIV:  if (fpu_rsp.done) begin issued_q <= 1'b0; tmp_q <= fpu_rsp.res;  st_q <= S_BMUL1; end
        S_BMUL1: if (fpu_rsp.done) begin issued_q <= 1'b0; tmp2_q <= fpu_rsp.res; st_q <= S_BMUL2; end
        S_BMUL2: if (fpu_rsp.done) begin issued_q <= 1'b0; tmp2_q <= fpu_rsp.res; st_q <= S_BADD;  end
        S_BADD: begin
          if (fpu_rsp.done) begin
            issued_q <= 1'b0;
            ss_q     <= fpu_rsp.res;
            scale_q  <= mag_q;
            st_q     <= S_AFTER;
          end
        end
        S_SDIV:  if (fpu_rsp.done) begin issued_q <= 1'b0; tmp_q <= fpu_rsp.res;  st_q <= S_SMUL; end
        S_SMUL:  if (fpu_rsp.done) begin issued_q <= 1'b0; tmp2_q <= fpu_rsp.res; st_q <= S_SADD; end
        S_SADD:  if (fpu_rsp.done) begin issued_q <= 1'b0; ss_q <= fpu_rsp.res;   st_q <= S_AFTER; end
        S_AFTER: begin
          if (last_q) begin
            st_q <= S_SQRT;
          end else begin
            seen_q <= 1'b1;
            st_q   <= S_IDLE;
          end
        end
        S_SQRT: if (fpu_rsp.done) begin issued_q <= 1'b0; root_q <= fpu_rsp.res; st_q <= S_QDIV; end
        S_QDIV: if (fpu_rsp.done) begin issued_q <= 1'b0; tmp_q <= fpu_rsp.res;  st_q <= S_CLAMP; end
        S_CLAMP: begin
          // saturate unless scale < 1e50 / root; a NaN root saturates too
          if (lt_pos(scale_q, tmp_q)) begin
            st_q <= S_FMUL;
          end else begin
            res_q <= DBL_NORM_MAX;
            st_q  <= S_EMIT;
          end
        end
        S_FMUL: if (fpu_rsp.done) begin issued_q <= 1'b0; res_q <= fpu_rsp.res; st_q <= S_EMIT; end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            scale_q   <= DBL_ZERO;
            ss_q      <= DBL_ONE;
            seen_q    <= 1'b0;
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `SEN_ASSERT(a_fpu_start_idle, fpu_req.start, !fpu_rsp.busy, "shared unit started while busy")
  `SEN_ASSERT(a_fpu_done_issued, fpu_rsp.done, issued_q, "shared unit result with no request")
  `SEN_ASSERT_NXT(a_one_in_work, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "item taken while one is in work")
  `SEN_ASSERT(a_scale_not_nan, 1'b1, !((&scale_q[62:52]) && (|scale_q[51:0])), "running scale became NaN")

endmodule

`default_nettype wire

/* test/scaled_euclidean_norm_checker.sv */
// Checker for scaled_euclidean_norm: watches both streams, predicts each norm, compares.
// Depends on sen_pkg for the double constants.
`timescale 1ns / 100ps

module scaled_euclidean_norm_checker import sen_pkg::*; (
  input  logic        clk_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  output int          fail_count_o,
  output int          norms_pending_o
);

  real         scale_q = 0.0;
  real         sumsq_q = 1.0;
  logic        multi_q = 1'b0;
  int          fails = 0;
  logic [63:0] norm_fifo[$];

  // correctly rounded square root, digit by digit on the mantissa
  function automatic logic [63:0] root_bits(input logic [63:0] u);
    logic [10:0] be;
    logic [51:0] fr;
    logic [63:0] m, q, r, t, pr;
    longint      k, oe;
    int          pos;
    be = u[62:52];
    fr = u[51:0];
    if (be == 11'h7FF) begin
      if (fr != 0) return u | DBL_QBIT;
      if (u[63]) return DBL_QNAN;
      return u;
    end
    if (u[62:0] == 0) return u;
    if (u[63]) return DBL_QNAN;
    if (be == 0) begin
      m = {12'h000, fr};
      k = -1074;
      while (m[52] == 1'b0) begin
        m = m << 1;
        k = k - 1;
      end
    end else begin
      m = {12'h001, fr};
      k = longint'(be) - 1075;
    end
    if (k[0]) begin
      m = m << 1;
      k = k - 1;
    end
    q = 0;
    r = 0;
    for (int i = 52; i >= 0; i--) begin
      pos = 2 * i - 52;
      pr = (pos >= 0) ? ((m >> pos) & 64'd3) : 64'd0;
      r = (r << 2) | pr;
      t = (q << 2) | 64'd1;
      if (r >= t) begin
        r = r - t;
        q = (q << 1) | 64'd1;
      end else begin
        q = q << 1;
      end
    end
    if (r > q) q = q + 1;
    oe = k / 2 + 26 + 1023;
    return (64'(oe - 1) << 52) + q;
  endfunction

  task automatic fold_element(input logic [63:0] xb);
    real mag, ratio;
    if ($bitstoreal(xb) == 0.0) return;
    mag = $bitstoreal({1'b0, xb[62:0]});
    if (scale_q < mag) begin
      ratio = scale_q / mag;
      sumsq_q = 1.0 + sumsq_q * ratio * ratio;
      scale_q = mag;
    end else begin
      ratio = (scale_q != 0.0) ? mag / scale_q : mag;
      sumsq_q = sumsq_q + ratio * ratio;
    end
  endtask

  task automatic clear_norm_state();
    scale_q = $bitstoreal(DBL_ZERO);
    sumsq_q = $bitstoreal(DBL_ONE);
    multi_q = 1'b0;
  endtask

  task automatic take_element(input logic [63:0] xb, input logic last);
    real root, nmax;
    if (!last) begin
      fold_element(xb);
      multi_q = 1'b1;
      return;
    end
    if (!multi_q) begin
      norm_fifo.push_back({1'b0, xb[62:0]});  // lone element: magnitude, no clamp
    end else begin
      fold_element(xb);
      root = $bitstoreal(root_bits($realtobits(sumsq_q)));
      nmax = $bitstoreal(DBL_NORM_MAX);
      if (scale_q < nmax / root) norm_fifo.push_back($realtobits(scale_q * root));
      else norm_fifo.push_back(DBL_NORM_MAX);
    end
    clear_norm_state();
  endtask

  assign fail_count_o    = fails;
  assign norms_pending_o = norm_fifo.size();

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (s_tvalid_i && s_tready_i) take_element(s_tdata_i, s_tlast_i);
    if (m_tvalid_i && m_tready_i) begin
      if (norm_fifo.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected norm %h", m_tdata_i);
      end else begin
        want = norm_fifo.pop_front();
        if (want !== m_tdata_i) begin
          fails++;
          if (fails <= 10)
            $display("norm_bits mismatch: expected %h actual %h", want, m_tdata_i);
        end
      end
    end
  end

endmodule

/* test/scaled_euclidean_norm_tb.sv */
// Testbench top for scaled_euclidean_norm: clock, reset, element stimulus and verdict.
// Depends on sen_pkg, the block and scaled_euclidean_norm_checker.
`timescale 1ns / 100ps

module scaled_euclidean_norm_tb import sen_pkg::*;;

  localparam int WATCHDOG_CYCLES = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  int          fail_count;
  int          norms_pending;
  int          idle_cnt = 0;
  logic        calm = 1'b0;   // no idling on either side while set

  always #5 clk_i = ~clk_i;

  scaled_euclidean_norm u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [63:0] element_bits
    .s_axis_tlast_i  (s_tlast),   // last_element
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [63:0] norm_bits
  );

  scaled_euclidean_norm_checker u_checker (
    .clk_i           (clk_i),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tlast_i       (s_tlast),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .fail_count_o    (fail_count),
    .norms_pending_o (norms_pending)
  );

  // result side: ready drops at random with a chance of 9 percent, never while calm
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 9);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_element(input logic [63:0] d, input logic last);
    if (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
  endtask

  // random element, weighted toward interesting exponents
  function automatic logic [63:0] pick_element();
    logic        sgn;
    logic [51:0] fr;
    sgn = 1'($urandom_range(1));
    fr = 52'({$urandom, $urandom});
    case ($urandom_range(11))
      0:       return {$urandom, $urandom};
      1:       return {sgn, 63'd0};
      2:       return {sgn, 11'h7FF, 52'd0};
      3:       return {sgn, 11'h7FF, fr | 52'd1};
      4:       return {sgn, 11'd0, fr};
      5:       return {sgn, 11'(1023 + 166 + $urandom_range(6) - 3), fr};
      6:       return {sgn, 11'($urandom_range(60)), fr};
      7:       return {sgn, 11'($urandom_range(2046, 1980)), fr};
      default: return {sgn, 11'(1023 + $urandom_range(80) - 40), fr};
    endcase
  endfunction

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++) send_element(pick_element(), i == len - 1);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone elements pass through as magnitudes, even NaN and infinity
    send_element({1'b1, 11'h400, 52'h1234}, 1'b1);
    send_element({1'b1, 11'h7FF, 52'd0}, 1'b1);
    send_element({1'b1, 11'h7FF, 52'h5}, 1'b1);
    send_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // all-zero vector, signed zeros skipped
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(DBL_ZERO, 1'b1);
    // 3-4-5 with a zero in between, smaller first
    send_element(64'h4008_0000_0000_0000, 1'b0);
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(64'hC010_0000_0000_0000, 1'b1);
    // saturation: near the clamp and by infinity
    send_element(DBL_NORM_MAX, 1'b0);
    send_element(DBL_NORM_MAX, 1'b1);
    send_element(64'h3FF0_0000_0000_0000, 1'b0);
    send_element(DBL_INF, 1'b1);
    // NaN inside a vector, subnormal extremes and the largest normal
    send_element(DBL_QNAN, 1'b0);
    send_element(64'h4000_0000_0000_0000, 1'b1);
    send_element(64'h0000_0000_0000_0001, 1'b0);
    send_element(64'h000F_FFFF_FFFF_FFFF, 1'b1);
    send_element(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_element(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);

    n = 19;
    while (n < 1200) begin
      if (n > 500 && n < 700) calm <= 1'b1;
      else calm <= 1'b0;
      if (n > 300 && n < 310) begin
        // hold off until every norm is back; waiting on the clock first lets the checker log the last item
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (norms_pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(9) == 0) begin
        send_vector(1);
        n += 1;
      end else begin
        int len;
        len = int'($urandom_range(6, 2));
        send_vector(len);
        n += len;
      end
    end
    s_tvalid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk_i);
    while (norms_pending != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
